### rtl/dtq_pkg.sv
package dtq_pkg;

  localparam int QueueDepth = 16;
  localparam int IdxW       = $clog2(QueueDepth);
  localparam int MaxResults = 16;
  localparam int FireCntW   = $clog2(MaxResults + 1);
  localparam int TimeW      = 48;
  localparam int HandleW    = 32;
  localparam int DelayW     = 32;
  localparam int CmdW       = 2;
  localparam int KindW      = 2;

  localparam logic [CmdW-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CmdW-1:0] CMD_CANCEL = 2'd1;
  localparam logic [CmdW-1:0] CMD_TICK   = 2'd2;

  localparam logic [KindW-1:0] KIND_PUSH   = 2'd0;
  localparam logic [KindW-1:0] KIND_CANCEL = 2'd1;
  localparam logic [KindW-1:0] KIND_FIRE   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic [CmdW-1:0]    cmd;
    logic [DelayW-1:0]  delay;
    logic [HandleW-1:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [HandleW-1:0] entry_handle;
    logic               ok;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    logic [TimeW-1:0]   deadline;
    logic [HandleW-1:0] id;
  } entry_t;

  // best entry found so far along the chain
  typedef struct packed {
    logic               found;
    logic [TimeW-1:0]   lag;
    logic [IdxW-1:0]    pos;
    logic [HandleW-1:0] id;
  } cand_t;

  typedef struct packed {
    logic               push;
    logic               remove;
    logic [IdxW-1:0]    rm_pos;
    logic               cancel_mode;
    logic [TimeW-1:0]   now;
    logic [HandleW-1:0] key;
    logic [TimeW-1:0]   push_deadline;
    logic [HandleW-1:0] push_id;
  } cell_ctl_t;

endpackage

### rtl/deadline_timer_queue_core.sv
// Bounded timer queue of dtq_pkg::QueueDepth entries held in a chain of cells,
// packed in insertion order. A push answers in the cycle after it is taken, and the
// next item can be taken in that same cycle. Cancel and tick search the queue
// through the cell chain: a candidate moves one cell per cycle, and each search
// is followed by a decide state. A cancel is answered from that decide state;
// a tick removes each entry that it fires and searches the chain again. A
// stalled output holds the decide state, and the idle state, until the output
// register frees up. Fired items are sent one behind the search so the final
// one carries last; at most dtq_pkg::MaxResults fire per tick, the rest on
// later ticks. A new item is taken only while the block is idle and the
// output register is free or being emptied.
module deadline_timer_queue_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  dtq_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output dtq_pkg::out_item_t  out_item
);

  localparam int N = dtq_pkg::QueueDepth;

  dtq_pkg::entry_t                  ents  [N];
  dtq_pkg::cand_t                   cands [N];
  dtq_pkg::cell_ctl_t               ctl;

  dtq_pkg::state_t                  state, state_next;
  logic [dtq_pkg::IdxW-1:0]         search_cnt, search_cnt_next;
  logic [dtq_pkg::TimeW-1:0]        now_time, now_time_next;
  logic [dtq_pkg::HandleW-1:0]      handle_counter, handle_counter_next;
  logic                             cancel_mode, cancel_mode_next;
  logic [dtq_pkg::HandleW-1:0]      key, key_next;
  logic [dtq_pkg::FireCntW-1:0]     fire_cnt, fire_cnt_next;
  logic [dtq_pkg::HandleW-1:0]      held, held_next;
  logic                             held_valid, held_valid_next;
  logic                             out_valid_next;
  dtq_pkg::out_item_t               out_item_next;
  logic                             out_free;
  logic                             full;
  logic                             push;
  logic                             remove;
  dtq_pkg::cand_t                   best;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      logic            prev_v;
      dtq_pkg::entry_t nxt;
      dtq_pkg::cand_t  cin;
      if (g == 0) begin : g_head
        assign prev_v = 1'b1;
        assign cin    = '0;
      end else begin : g_body
        assign prev_v = ents[g-1].valid;
        assign cin    = cands[g-1];
      end
      if (g == N - 1) begin : g_tail
        assign nxt = '0;
      end else begin : g_mid
        assign nxt = ents[g+1];
      end
      dtq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .idx        (dtq_pkg::IdxW'(g)),
        .ctl        (ctl),
        .prev_valid (prev_v),
        .next_entry (nxt),
        .cand_in    (cin),
        .entry      (ents[g]),
        .cand_out   (cands[g])
      );
    end
  endgenerate

  assign full     = ents[N-1].valid;
  assign best     = cands[N-1];
  assign out_free = !out_valid || !out_stall;

  assign ctl = '{
    push:          push,
    remove:        remove,
    rm_pos:        best.pos,
    cancel_mode:   cancel_mode,
    now:           now_time,
    key:           key,
    push_deadline: now_time + {{(dtq_pkg::TimeW - dtq_pkg::DelayW){1'b0}}, in_item.delay},
    push_id:       handle_counter + 1'b1
  };

  always_comb begin
    state_next          = state;
    search_cnt_next     = search_cnt;
    now_time_next       = now_time;
    handle_counter_next = handle_counter;
    cancel_mode_next    = cancel_mode;
    key_next            = key;
    fire_cnt_next       = fire_cnt;
    held_next           = held;
    held_valid_next     = held_valid;
    out_valid_next      = out_valid && out_stall;
    out_item_next       = out_item;
    push                = 1'b0;
    remove              = 1'b0;
    in_stall            = 1'b1;

    unique case (state)
      dtq_pkg::ST_IDLE: begin
        in_stall = !out_free;
        if (in_valid && out_free) begin
          if (in_item.cmd == dtq_pkg::CMD_PUSH) begin
            out_valid_next = 1'b1;
            if (full) begin
              out_item_next = '{kind: dtq_pkg::KIND_PUSH, entry_handle: '0,
                                ok: 1'b0, last: 1'b1};
            end else begin
              push                = 1'b1;
              handle_counter_next = handle_counter + 1'b1;
              out_item_next = '{kind: dtq_pkg::KIND_PUSH,
                                entry_handle: handle_counter + 1'b1,
                                ok: 1'b1, last: 1'b1};
            end
          end else if (in_item.cmd == dtq_pkg::CMD_CANCEL) begin
            key_next         = in_item.handle;
            cancel_mode_next = 1'b1;
            search_cnt_next  = '0;
            state_next       = dtq_pkg::ST_SEARCH;
          end else if (in_item.cmd == dtq_pkg::CMD_TICK) begin
            now_time_next    = now_time + 1'b1;
            cancel_mode_next = 1'b0;
            fire_cnt_next    = '0;
            held_valid_next  = 1'b0;
            search_cnt_next  = '0;
            state_next       = dtq_pkg::ST_SEARCH;
          end
        end
      end

      dtq_pkg::ST_SEARCH: begin
        search_cnt_next = search_cnt + 1'b1;
        if (search_cnt == dtq_pkg::IdxW'(N - 1)) begin
          state_next = dtq_pkg::ST_DECIDE;
        end
      end

      dtq_pkg::ST_DECIDE: begin
        if (out_free) begin
          if (cancel_mode) begin
            remove         = best.found;
            out_valid_next = 1'b1;
            out_item_next  = '{kind: dtq_pkg::KIND_CANCEL, entry_handle: key,
                               ok: best.found, last: 1'b1};
            state_next     = dtq_pkg::ST_IDLE;
          end else if (best.found &&
                       (fire_cnt != dtq_pkg::FireCntW'(dtq_pkg::MaxResults))) begin
            remove          = 1'b1;
            held_next       = best.id;
            held_valid_next = 1'b1;
            fire_cnt_next   = fire_cnt + 1'b1;
            if (held_valid) begin
              out_valid_next = 1'b1;
              out_item_next  = '{kind: dtq_pkg::KIND_FIRE, entry_handle: held,
                                 ok: 1'b1, last: 1'b0};
            end
            search_cnt_next = '0;
            state_next      = dtq_pkg::ST_SEARCH;
          end else begin
            if (held_valid) begin
              out_valid_next = 1'b1;
              out_item_next  = '{kind: dtq_pkg::KIND_FIRE, entry_handle: held,
                                 ok: 1'b1, last: 1'b1};
            end
            held_valid_next = 1'b0;
            state_next      = dtq_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_next = dtq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= dtq_pkg::ST_IDLE;
      search_cnt     <= '0;
      now_time       <= '0;
      handle_counter <= '0;
      cancel_mode    <= 1'b0;
      fire_cnt       <= '0;
      held_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      search_cnt     <= search_cnt_next;
      now_time       <= now_time_next;
      handle_counter <= handle_counter_next;
      cancel_mode    <= cancel_mode_next;
      fire_cnt       <= fire_cnt_next;
      held_valid     <= held_valid_next;
      out_valid      <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key      <= key_next;
    held     <= held_next;
    out_item <= out_item_next;
  end

endmodule

### rtl/dtq_cell.sv
module dtq_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [dtq_pkg::IdxW-1:0] idx,
  input  dtq_pkg::cell_ctl_t      ctl,
  input  logic                    prev_valid,
  input  dtq_pkg::entry_t         next_entry,
  input  dtq_pkg::cand_t          cand_in,
  output dtq_pkg::entry_t         entry,
  output dtq_pkg::cand_t          cand_out
);

  logic                          valid;
  logic [dtq_pkg::TimeW-1:0]     deadline;
  logic [dtq_pkg::HandleW-1:0]   id;
  logic                          valid_next;
  logic [dtq_pkg::TimeW-1:0]     deadline_next;
  logic [dtq_pkg::HandleW-1:0]   id_next;
  logic                          take_next;
  logic                          write_push;
  logic [dtq_pkg::TimeW-1:0]     lag;
  logic                          due;
  logic                          match;
  logic                          take_own;
  dtq_pkg::cand_t                cand;
  dtq_pkg::cand_t                cand_next;

  assign entry    = '{valid: valid, deadline: deadline, id: id};
  assign cand_out = cand;

  // removal shifts younger entries down; push fills the first free cell
  assign take_next  = ctl.remove && (idx >= ctl.rm_pos);
  assign write_push = ctl.push && prev_valid && !valid;

  always_comb begin
    valid_next    = valid;
    deadline_next = deadline;
    id_next       = id;
    if (take_next) begin
      valid_next    = next_entry.valid;
      deadline_next = next_entry.deadline;
      id_next       = next_entry.id;
    end else if (write_push) begin
      valid_next    = 1'b1;
      deadline_next = ctl.push_deadline;
      id_next       = ctl.push_id;
    end
  end

  assign lag   = ctl.now - deadline;
  assign due   = valid && !lag[dtq_pkg::TimeW-1];
  assign match = valid && (id == ctl.key);

  // older cells win ties: only a strictly larger lag replaces the candidate
  always_comb begin
    if (ctl.cancel_mode) begin
      take_own = match && !cand_in.found;
    end else begin
      take_own = due && (!cand_in.found || (lag > cand_in.lag));
    end
    if (take_own) begin
      cand_next = '{found: 1'b1, lag: lag, pos: idx, id: id};
    end else begin
      cand_next = cand_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    deadline <= deadline_next;
    id       <= id_next;
    cand     <= cand_next;
  end

endmodule

### rtl/dtq_checker.sv
module dtq_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input dtq_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input dtq_pkg::out_item_t out_item
);

  // a held result must not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  // push answers come back on the next cycle
  a_push_answer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_item.cmd == dtq_pkg::CMD_PUSH)
    |=> out_valid && (out_item.kind == dtq_pkg::KIND_PUSH))
    else $error("push not answered in one cycle");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.kind != dtq_pkg::KIND_FIRE) |-> out_item.last)
    else $error("push or cancel answer without last");

  a_fire_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.kind == dtq_pkg::KIND_FIRE) |-> out_item.ok)
    else $error("fired item without ok");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.kind == dtq_pkg::KIND_PUSH) && !out_item.ok
    |-> (out_item.entry_handle == '0))
    else $error("rejected push carries a handle");

endmodule

bind deadline_timer_queue_core dtq_checker u_dtq_checker (.*);
